/* hdl/frame_byte_quality_estimator_defines.svh */
// assertion macros shared by the frame byte quality estimator modules
`ifndef FRAME_BYTE_QUALITY_ESTIMATOR_DEFINES_SVH
`define FRAME_BYTE_QUALITY_ESTIMATOR_DEFINES_SVH

`ifndef SYNTHESIS
// condition holds in the same cycle
`define FBQE_ASSERT_NOW(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("fbqe assertion failed");
// condition implies expr in the next cycle
`define FBQE_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("fbqe assertion failed");
`else
`define FBQE_ASSERT_NOW(label, clk, rst_n, cond, expr)
`define FBQE_ASSERT_NEXT(label, clk, rst_n, cond, expr)
`endif

`endif

/* hdl/fbqe_pkg.sv */
// shared types, constants and functions of the frame byte quality estimator
package fbqe_pkg;

    localparam int LENGTH_BITS   = 20;
    localparam int SAMPLE_TARGET = 256;
    localparam int SAMPLE_SHIFT  = $clog2(SAMPLE_TARGET);
    localparam int STRIDE_BITS   = LENGTH_BITS - SAMPLE_SHIFT;
    localparam int BYTE_BITS     = 8;
    // at most 2*SAMPLE_TARGET-1 samples in one frame
    localparam int COUNT_BITS    = $clog2(2 * SAMPLE_TARGET);
    localparam int SUM_BITS      = COUNT_BITS + BYTE_BITS;
    localparam int QUO_BITS      = BYTE_BITS;
    localparam int STEP_BITS     = $clog2(QUO_BITS);
    localparam int IN_BITS       = ((BYTE_BITS + LENGTH_BITS + 7) / 8) * 8;
    localparam int OUT_BITS      = 24;

    localparam logic [BYTE_BITS-1:0] DIM_LIMIT          = 8'd72;
    localparam logic [BYTE_BITS-1:0] BRIGHT_LIMIT       = 8'd206;
    localparam logic [BYTE_BITS-1:0] LOW_CONTRAST_LIMIT = 8'd80;

    // register map
    localparam logic REG_PROFILE_INDEX = 1'b0;

    typedef enum logic [1:0] {
        PROFILE_SMALL  = 2'd0,
        PROFILE_MEDIUM = 2'd1,
        PROFILE_LARGE  = 2'd2,
        PROFILE_HUGE   = 2'd3
    } fbqe_profile_t;

    typedef enum logic [2:0] {
        ADV_HOLD                 = 3'd0,
        ADV_BOOST_LIGHT          = 3'd1,
        ADV_REDUCE_LIGHT         = 3'd2,
        ADV_BOOST_CONTRAST       = 3'd3,
        ADV_BOOST_LIGHT_CONTRAST = 3'd4,
        ADV_COMPRESS_NEXT        = 3'd5
    } fbqe_advice_t;

    typedef enum logic [2:0] {
        ST_ACCUM  = 3'b001,
        ST_DIVIDE = 3'b010,
        ST_EMIT   = 3'b100
    } fbqe_state_t;

    typedef struct packed {
        logic accept;    // input beat taken
        logic finish;    // taken beat closes the frame
        logic div_step;  // one quotient bit
        logic load_out;  // result into output register
    } fbqe_cmd_t;

    typedef struct packed {
        logic div_last;  // final quotient bit this cycle
    } fbqe_status_t;

    function automatic logic [LENGTH_BITS-1:0] large_threshold(input logic [1:0] profile);
        logic [LENGTH_BITS-1:0] thr;
        case (fbqe_profile_t'(profile))
            PROFILE_SMALL:  thr = LENGTH_BITS'(24000);
            PROFILE_MEDIUM: thr = LENGTH_BITS'(52000);
            PROFILE_LARGE:  thr = LENGTH_BITS'(90000);
            default:        thr = LENGTH_BITS'(150000);
        endcase
        return thr;
    endfunction

endpackage

/* hdl/frame_byte_quality_estimator.sv */
// Frame byte quality estimator: takes the bytes of one compressed frame as input beats, latches
// the frame length from the first byte and samples every stride-th byte (stride 1 up to 256
// bytes, else length shifted right by 8) into a sum, count, minimum and maximum. A beat with
// tlast set closes the frame and yields one result beat: mean brightness, contrast, four flags
// and an advice code; a frame length of 0 gives the fixed empty result. Ordinary bytes are
// accepted whenever the block is in its accumulate state. After the closing byte is taken,
// the bit-serial restoring divider forms the mean (one quotient bit per cycle), then the
// result is loaded into the output register, a load that waits while a previous result
// has not yet been taken; only then is the next beat taken. While a result waits in the
// output register, bytes of the next frame are still accepted. The large-frame threshold is set
// by profile_index over the register port (0: 24000, 1: 52000, 2: 90000, 3: 150000 bytes).
module frame_byte_quality_estimator (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [7:0] byte_value, [27:8] frame_length, [31:28] zero
    input  logic        s_tlast,   // last_byte
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] brightness, [15:8] contrast, [16] dim_flag,
                                   // [17] bright_flag, [18] low_contrast_flag,
                                   // [19] large_frame_flag, [22:20] advice_code, [23] zero
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import fbqe_pkg::*;

    logic [1:0]   profile_reg;
    logic         reg_write;
    fbqe_cmd_t    cmd;
    fbqe_status_t status;

    // register port: single register, no wait states
    assign pready    = 1'b1;
    assign reg_write = psel && penable && pwrite && (paddr[2] == REG_PROFILE_INDEX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            profile_reg <= 2'd0;
        end
        else if (reg_write)
        begin
            profile_reg <= pwdata[1:0];
        end
    end

    // reads outside the register map return zero
    assign prdata = (paddr[2] == REG_PROFILE_INDEX) ? {30'd0, profile_reg} : 32'd0;

    // sequencing of accept, divide and result hand-off
    fbqe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // sampling, mean division and result payload
    fbqe_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .byte_value    (s_tdata[7:0]),
        .frame_length  (s_tdata[8 +: LENGTH_BITS]),
        .profile_index (profile_reg),
        .status        (status),
        .result_data   (m_tdata)
    );

endmodule

/* hdl/fbqe_datapath.sv */
// sampling accumulators, restoring divider and result register
`include "frame_byte_quality_estimator_defines.svh"

module fbqe_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  fbqe_pkg::fbqe_cmd_t             cmd,
    input  logic [7:0]                      byte_value,
    input  logic [fbqe_pkg::LENGTH_BITS-1:0] frame_length,
    input  logic [1:0]                      profile_index,
    output fbqe_pkg::fbqe_status_t          status,
    output logic [fbqe_pkg::OUT_BITS-1:0]   result_data
);
    import fbqe_pkg::*;

    logic [LENGTH_BITS-1:0]   pos_reg, pos_next;
    logic [LENGTH_BITS:0]     nsp_reg, nsp_next;
    logic [STRIDE_BITS-1:0]   stride_reg, stride_next;
    logic [LENGTH_BITS-1:0]   len_reg, len_next;
    logic [SUM_BITS-1:0]      sum_reg, sum_next;
    logic [COUNT_BITS-1:0]    cnt_reg, cnt_next;
    logic [BYTE_BITS-1:0]     min_reg, min_next;
    logic [BYTE_BITS-1:0]     max_reg, max_next;

    logic [COUNT_BITS-1:0]    rem_reg;
    logic [QUO_BITS-1:0]      quo_reg;
    logic [COUNT_BITS-1:0]    div_count_reg;
    logic [BYTE_BITS-1:0]     contrast_reg;
    logic                     empty_reg;
    logic                     large_reg;
    logic [STEP_BITS-1:0]     step_reg;
    logic [OUT_BITS-1:0]      out_data_reg;

    logic                     first_byte;
    logic [LENGTH_BITS-1:0]   len_eff;
    logic [STRIDE_BITS-1:0]   stride_eff;
    logic [LENGTH_BITS:0]     nsp_eff;
    logic                     in_range;
    logic                     take;
    logic [COUNT_BITS:0]      trial;
    logic                     trial_ge;

    fbqe_advice_t             advice;
    logic                     dim_f, bright_f, lowc_f, large_f;
    logic [BYTE_BITS-1:0]     bright_v, contrast_v;

    // frame state with the first byte latched in
    always_comb
    begin
        first_byte = (pos_reg == '0);
        len_eff    = first_byte ? frame_length : len_reg;
        if (first_byte)
        begin
            stride_eff = (frame_length > LENGTH_BITS'(SAMPLE_TARGET)) ?
                         frame_length[LENGTH_BITS-1:SAMPLE_SHIFT] : STRIDE_BITS'(1);
        end
        else
        begin
            stride_eff = stride_reg;
        end
        nsp_eff  = first_byte ? '0 : nsp_reg;
        in_range = (pos_reg < len_eff);
        take     = in_range && ({1'b0, pos_reg} == nsp_eff);

        pos_next    = in_range ? pos_reg + 1'b1 : pos_reg;
        nsp_next    = take ? nsp_eff + (LENGTH_BITS+1)'(stride_eff) : nsp_eff;
        stride_next = stride_eff;
        len_next    = len_eff;
        sum_next    = take ? sum_reg + SUM_BITS'(byte_value) : sum_reg;
        cnt_next    = take ? cnt_reg + 1'b1 : cnt_reg;
        min_next    = (take && (byte_value < min_reg)) ? byte_value : min_reg;
        max_next    = (take && (byte_value > max_reg)) ? byte_value : max_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            nsp_reg    <= '0;
            stride_reg <= STRIDE_BITS'(1);
            len_reg    <= '0;
            sum_reg    <= '0;
            cnt_reg    <= '0;
            min_reg    <= '1;
            max_reg    <= '0;
        end
        else if (cmd.finish)
        begin
            pos_reg    <= '0;
            nsp_reg    <= '0;
            stride_reg <= STRIDE_BITS'(1);
            len_reg    <= '0;
            sum_reg    <= '0;
            cnt_reg    <= '0;
            min_reg    <= '1;
            max_reg    <= '0;
        end
        else if (cmd.accept)
        begin
            pos_reg    <= pos_next;
            nsp_reg    <= nsp_next;
            stride_reg <= stride_next;
            len_reg    <= len_next;
            sum_reg    <= sum_next;
            cnt_reg    <= cnt_next;
            min_reg    <= min_next;
            max_reg    <= max_next;
        end
    end

    // restoring division, quotient fits a byte so the top bits seed the remainder
    always_comb
    begin
        trial    = {rem_reg, quo_reg[QUO_BITS-1]};
        trial_ge = (trial >= {1'b0, div_count_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else if (cmd.finish)
        begin
            step_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            step_reg <= step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            rem_reg       <= sum_next[SUM_BITS-1:QUO_BITS];
            quo_reg       <= sum_next[QUO_BITS-1:0];
            div_count_reg <= cnt_next;
            contrast_reg  <= max_next - min_next;
            empty_reg     <= (len_eff == '0) || (cnt_next == '0);
            large_reg     <= (len_eff > large_threshold(profile_index));
        end
        else if (cmd.div_step)
        begin
            rem_reg <= trial_ge ? COUNT_BITS'(trial - {1'b0, div_count_reg})
                                : trial[COUNT_BITS-1:0];
            quo_reg <= {quo_reg[QUO_BITS-2:0], trial_ge};
        end
    end

    assign status.div_last = (step_reg == STEP_BITS'(QUO_BITS - 1));

    // flags and advice from the finished quotient
    always_comb
    begin
        if (empty_reg)
        begin
            bright_v   = '0;
            contrast_v = '0;
            dim_f      = 1'b1;
            bright_f   = 1'b0;
            lowc_f     = 1'b1;
            large_f    = 1'b0;
            advice     = ADV_BOOST_LIGHT;
        end
        else
        begin
            bright_v   = quo_reg;
            contrast_v = contrast_reg;
            dim_f      = (quo_reg < DIM_LIMIT);
            bright_f   = !dim_f && (quo_reg > BRIGHT_LIMIT);
            lowc_f     = (contrast_reg < LOW_CONTRAST_LIMIT);
            large_f    = large_reg;
            if (lowc_f)
            begin
                advice = dim_f ? ADV_BOOST_LIGHT_CONTRAST : ADV_BOOST_CONTRAST;
            end
            else if (dim_f)
            begin
                advice = ADV_BOOST_LIGHT;
            end
            else if (bright_f)
            begin
                advice = ADV_REDUCE_LIGHT;
            end
            else if (large_f)
            begin
                advice = ADV_COMPRESS_NEXT;
            end
            else
            begin
                advice = ADV_HOLD;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_data_reg <= {1'b0, advice, large_f, lowc_f, bright_f, dim_f,
                             contrast_v, bright_v};
        end
    end

    assign result_data = out_data_reg;

    `FBQE_ASSERT_NEXT(a_frame_clears, clk, rst_n, cmd.finish, pos_reg == '0 && cnt_reg == '0)
    `FBQE_ASSERT_NOW(a_rem_below_divisor, clk, rst_n, cmd.div_step && !empty_reg, rem_reg < div_count_reg)

endmodule

/* hdl/fbqe_ctrl.sv */
// controller: accumulate, divide and hand-off sequencing
`include "frame_byte_quality_estimator_defines.svh"

module fbqe_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tlast,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  fbqe_pkg::fbqe_status_t status,
    output fbqe_pkg::fbqe_cmd_t    cmd
);
    import fbqe_pkg::*;

    fbqe_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;

    assign s_tready = (state_reg == ST_ACCUM);
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd            = '0;
        cmd.accept     = s_tvalid && s_tready;
        cmd.finish     = s_tvalid && s_tready && s_tlast;
        case (state_reg)
            ST_ACCUM:
            begin
                if (cmd.finish)
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_ACCUM;
                end
            end
            default:
            begin
                state_next = ST_ACCUM;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACCUM;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `FBQE_ASSERT_NEXT(a_last_starts_divide, clk, rst_n, cmd.finish, state_reg == ST_DIVIDE && !s_tready)
    `FBQE_ASSERT_NOW(a_load_needs_room, clk, rst_n, cmd.load_out, !out_valid_reg || m_tready)

endmodule
